// ===== design/rfa_pkg.sv =====
package rfa_pkg;

    localparam int NUM_WIDTH    = 16;
    localparam int PROD_W       = 2 * NUM_WIDTH + 1;
    localparam int SUM_W        = 2 * NUM_WIDTH + 2;
    localparam int MAG_W        = 2 * NUM_WIDTH + 1;
    localparam int DEN_W        = 2 * NUM_WIDTH;
    localparam int RES_NUM_BITS = 34;
    localparam int RES_DEN_BITS = 32;
    localparam int IN_DATA_W    = ((4 * NUM_WIDTH + 7) / 8) * 8;
    localparam int IN_PAD_W     = IN_DATA_W - 4 * NUM_WIDTH;
    localparam int OUT_DATA_W   = ((RES_NUM_BITS + RES_DEN_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - RES_NUM_BITS - RES_DEN_BITS;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DIVZ = 2'd1,
        STAT_ZDEN = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_REDUCE,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic signed [SUM_W-1:0]  num;
        logic        [DEN_W-1:0]  den;
    } t_work;

endpackage

// ===== design/rational_fraction_alu.sv =====
// Exact add, subtract, multiply or divide of two fractions, reduced to lowest terms with a
// positive denominator. A two-stage front end forms the cross products and checks for zero
// denominators and division by a zero fraction, then hands the item through a two-entry queue
// to the back end. The back end runs a binary gcd one step a cycle, each subtraction followed
// by at least one halving, on the 33-bit magnitude and 32-bit denominator, and then a restoring
// divide of numerator and denominator by the gcd; error items skip both. The back end handles
// one item at a time, while the front end and queue keep accepting up to four items ahead of it.
module rational_fraction_alu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rfa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // res_num, res_den, zero padding
    output logic [rfa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]                     o_m_axis_tuser
);

    localparam int N = rfa_pkg::NUM_WIDTH;

    logic                               push;
    logic                               push_ready;
    rfa_pkg::t_work                     front_work;
    logic                               q_valid;
    logic                               q_pop;
    rfa_pkg::t_work                     q_work;
    logic signed [rfa_pkg::SUM_W-1:0]   res_num;
    logic        [rfa_pkg::DEN_W-1:0]   res_den;
    rfa_pkg::t_status                   res_stat;

    rfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (rfa_pkg::t_kind'(i_s_axis_tuser)),
        .i_a_num      ($signed(i_s_axis_tdata[N-1:0])),
        .i_a_den      (i_s_axis_tdata[2*N-1:N]),
        .i_b_num      ($signed(i_s_axis_tdata[3*N-1:2*N])),
        .i_b_den      (i_s_axis_tdata[4*N-1:3*N]),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_work       (front_work)
    );

    rfa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_work       (front_work),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_work       (q_work)
    );

    rfa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_work   (q_work),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_num    (res_num),
        .o_den    (res_den),
        .o_status (res_stat)
    );

    assign o_m_axis_tdata = {{rfa_pkg::OUT_PAD_W{1'b0}},
                             rfa_pkg::RES_DEN_BITS'(res_den),
                             rfa_pkg::RES_NUM_BITS'(res_num)};
    assign o_m_axis_tuser = res_stat;

endmodule

// ===== design/rfa_front.sv =====
module rfa_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  rfa_pkg::t_kind                         i_kind,
    input  logic signed [rfa_pkg::NUM_WIDTH-1:0]   i_a_num,
    input  logic        [rfa_pkg::NUM_WIDTH-1:0]   i_a_den,
    input  logic signed [rfa_pkg::NUM_WIDTH-1:0]   i_b_num,
    input  logic        [rfa_pkg::NUM_WIDTH-1:0]   i_b_den,
    output logic                                   o_push,
    input  logic                                   i_push_ready,
    output rfa_pkg::t_work                         o_work
);

    logic                                  r_v1;
    logic signed [rfa_pkg::SUM_W-1:0]      r_t1;
    logic signed [rfa_pkg::SUM_W-1:0]      r_t2;
    logic                                  r_sub;
    logic        [rfa_pkg::DEN_W-1:0]      r_den1;
    rfa_pkg::t_status                      r_stat1;
    logic                                  r_v2;
    rfa_pkg::t_work                        r_work;

    logic                                  en1;
    logic                                  en2;
    logic signed [rfa_pkg::NUM_WIDTH:0]    bsel;
    logic        [rfa_pkg::NUM_WIDTH-1:0]  bmag;
    logic        [rfa_pkg::NUM_WIDTH-1:0]  dsel;
    logic signed [rfa_pkg::PROD_W-1:0]     p1;
    logic signed [rfa_pkg::PROD_W-1:0]     p2;
    logic signed [rfa_pkg::SUM_W-1:0]      n_t1;
    logic signed [rfa_pkg::SUM_W-1:0]      n_t2;
    logic                                  n_sub;
    rfa_pkg::t_status                      n_stat;

    assign en2     = !r_v2 || i_push_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_push  = r_v2;
    assign o_work  = r_work;

    always_comb begin
        bmag = i_b_num[rfa_pkg::NUM_WIDTH-1] ? rfa_pkg::NUM_WIDTH'(-i_b_num)
                                             : rfa_pkg::NUM_WIDTH'(i_b_num);
        bsel = (i_kind == rfa_pkg::KIND_MUL) ? (rfa_pkg::NUM_WIDTH+1)'(i_b_num)
                                             : $signed({1'b0, i_b_den});
        dsel = (i_kind == rfa_pkg::KIND_DIV) ? bmag : i_b_den;
        p1   = i_a_num * bsel;
        p2   = i_b_num * $signed({1'b0, i_a_den});
        n_t1 = rfa_pkg::SUM_W'(p1);
        n_t2 = rfa_pkg::SUM_W'(p2);
        n_sub = 1'b0;
        unique case (i_kind)
            rfa_pkg::KIND_ADD: begin
                n_sub = 1'b0;
            end
            rfa_pkg::KIND_SUB: begin
                n_sub = 1'b1;
            end
            rfa_pkg::KIND_MUL: begin
                n_t2 = '0;
            end
            rfa_pkg::KIND_DIV: begin
                n_t1  = '0;
                n_t2  = rfa_pkg::SUM_W'(p1);
                n_sub = i_b_num[rfa_pkg::NUM_WIDTH-1];
            end
            default: begin
                n_sub = 1'b0;
            end
        endcase
        priority if (i_a_den == '0 || i_b_den == '0) begin
            n_stat = rfa_pkg::STAT_ZDEN;
        end else if (i_kind == rfa_pkg::KIND_DIV && i_b_num == '0) begin
            n_stat = rfa_pkg::STAT_DIVZ;
        end else begin
            n_stat = rfa_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
        if (en1 && i_valid) begin
            r_t1    <= n_t1;
            r_t2    <= n_t2;
            r_sub   <= n_sub;
            r_den1  <= rfa_pkg::DEN_W'(i_a_den) * rfa_pkg::DEN_W'(dsel);
            r_stat1 <= n_stat;
        end
        if (en2 && r_v1) begin
            r_work.status <= r_stat1;
            r_work.num    <= r_sub ? (r_t1 - r_t2) : (r_t1 + r_t2);
            r_work.den    <= r_den1;
        end
    end

endmodule

// ===== design/rfa_queue.sv =====
module rfa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  rfa_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_pop,
    output rfa_pkg::t_work o_work
);

    rfa_pkg::t_work r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_work       = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ===== design/rfa_back.sv =====
module rfa_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  rfa_pkg::t_work                      i_work,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rfa_pkg::SUM_W-1:0]    o_num,
    output logic        [rfa_pkg::DEN_W-1:0]    o_den,
    output rfa_pkg::t_status                    o_status
);

    localparam int KW = $clog2(rfa_pkg::MAG_W + 1);
    localparam int CW = $clog2(rfa_pkg::MAG_W);
    localparam int RW = rfa_pkg::DEN_W + 1;

    rfa_pkg::t_state                    r_state;
    rfa_pkg::t_state                    n_state;
    logic [rfa_pkg::MAG_W-1:0]          r_a;
    logic [rfa_pkg::MAG_W-1:0]          r_b;
    logic [KW-1:0]                      r_k;
    logic [rfa_pkg::DEN_W-1:0]          r_g;
    logic [rfa_pkg::MAG_W-1:0]          r_qa;
    logic [rfa_pkg::MAG_W-1:0]          r_qb;
    logic [RW-1:0]                      r_ra;
    logic [RW-1:0]                      r_rb;
    logic [CW-1:0]                      r_cnt;
    logic                               r_neg;
    rfa_pkg::t_status                   r_stat;
    logic                               r_out_valid;
    logic signed [rfa_pkg::SUM_W-1:0]   r_out_num;
    logic        [rfa_pkg::DEN_W-1:0]   r_out_den;
    rfa_pkg::t_status                   r_out_stat;

    logic                               out_free;
    logic                               load_out;
    logic [rfa_pkg::MAG_W-1:0]          mag_in;
    logic [RW-1:0]                      ta;
    logic [RW-1:0]                      tb;
    logic                               qa_bit;
    logic                               qb_bit;
    logic [RW-1:0]                      g_ext;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_num    = r_out_num;
    assign o_den    = r_out_den;
    assign o_status = r_out_stat;
    assign mag_in   = i_work.num[rfa_pkg::SUM_W-1] ? rfa_pkg::MAG_W'(-i_work.num)
                                                   : rfa_pkg::MAG_W'(i_work.num);
    assign g_ext    = {1'b0, r_g};
    assign ta       = {r_ra[RW-2:0], r_qa[rfa_pkg::MAG_W-1]};
    assign tb       = {r_rb[RW-2:0], r_qb[rfa_pkg::MAG_W-1]};
    assign qa_bit   = (ta >= g_ext);
    assign qb_bit   = (tb >= g_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_work.status == rfa_pkg::STAT_OK) ? rfa_pkg::S_SHIFT
                                                                  : rfa_pkg::S_DONE;
                end
            end
            rfa_pkg::S_SHIFT: begin
                if (r_a[0] || r_b[0]) begin
                    n_state = rfa_pkg::S_REDUCE;
                end
            end
            rfa_pkg::S_REDUCE: begin
                if (r_a == '0) begin
                    n_state = rfa_pkg::S_DIV;
                end
            end
            rfa_pkg::S_DIV: begin
                if (r_cnt == CW'(rfa_pkg::MAG_W - 1)) begin
                    n_state = rfa_pkg::S_DONE;
                end
            end
            rfa_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = (r_state == rfa_pkg::S_IDLE) && i_valid;
        load_out = (r_state == rfa_pkg::S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        unique case (r_state)
            rfa_pkg::S_IDLE: begin
                r_stat <= i_work.status;
                r_neg  <= i_work.num[rfa_pkg::SUM_W-1];
                r_a    <= mag_in;
                r_b    <= (i_work.den == '0) ? rfa_pkg::MAG_W'(1)
                                             : rfa_pkg::MAG_W'(i_work.den);
                r_qa   <= mag_in;
                r_qb   <= (i_work.den == '0) ? rfa_pkg::MAG_W'(1)
                                             : rfa_pkg::MAG_W'(i_work.den);
                r_k    <= '0;
            end
            rfa_pkg::S_SHIFT: begin
                if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + KW'(1);
                end
            end
            rfa_pkg::S_REDUCE: begin
                priority if (r_a == '0) begin
                    r_g   <= rfa_pkg::DEN_W'(r_b) << r_k;
                    r_ra  <= '0;
                    r_rb  <= '0;
                    r_cnt <= '0;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
            rfa_pkg::S_DIV: begin
                r_ra  <= qa_bit ? (ta - g_ext) : ta;
                r_rb  <= qb_bit ? (tb - g_ext) : tb;
                r_qa  <= {r_qa[rfa_pkg::MAG_W-2:0], qa_bit};
                r_qb  <= {r_qb[rfa_pkg::MAG_W-2:0], qb_bit};
                r_cnt <= r_cnt + CW'(1);
            end
            rfa_pkg::S_DONE: begin
                if (load_out) begin
                    r_out_stat <= r_stat;
                    if (r_stat == rfa_pkg::STAT_OK) begin
                        r_out_num <= r_neg ? -rfa_pkg::SUM_W'(r_qa)
                                           : rfa_pkg::SUM_W'(r_qa);
                        r_out_den <= rfa_pkg::DEN_W'(r_qb);
                    end else begin
                        r_out_num <= '0;
                        r_out_den <= '0;
                    end
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    a_reduce_b_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfa_pkg::S_REDUCE) |-> (r_b != '0))
        else $error("gcd operand b reached zero");

    a_div_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfa_pkg::S_DIV) |-> (r_cnt < CW'(rfa_pkg::MAG_W - 1)
                                         || r_cnt == CW'(rfa_pkg::MAG_W - 1)))
        else $error("divider count out of range");

    a_ok_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_stat == rfa_pkg::STAT_OK |=> (r_out_den != '0))
        else $error("reduced denominator is zero on a good item");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_stat != rfa_pkg::STAT_OK |=> (r_out_num == '0 && r_out_den == '0))
        else $error("error item carries a value");

endmodule
